>>> hw/rtl/hb2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hb2d_pkg: shared types and constants of the 2-D histogram
// Register map, item codes, field widths and the configuration bundle.
// ----------------------------------------------------------------------------
package hb2d_pkg;

    // APB register file
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_X_MIN   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_X_MAX   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_Y_MIN   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_Y_MAX   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_X_SCALE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_Y_SCALE = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_X_WIDTH = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_Y_WIDTH = 3'd7;

    // Item codes
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_PEAK   = 2'd2;

    // Field widths
    localparam int VAL_W   = 32;
    localparam int WIDTH_W = 31;
    localparam int BIN_W   = 4;
    localparam int CNT_W   = 32;

    // Reset values of the registers
    localparam logic signed [VAL_W-1:0] X_MIN_RST   = 32'sd0;
    localparam logic signed [VAL_W-1:0] X_MAX_RST   = 32'sd65536;
    localparam logic signed [VAL_W-1:0] Y_MIN_RST   = 32'sd0;
    localparam logic signed [VAL_W-1:0] Y_MAX_RST   = 32'sd65536;
    localparam logic [VAL_W-1:0]        SCALE_RST   = 32'd1048576;
    localparam logic [WIDTH_W-1:0]      WIDTH_RST   = 31'd4096;

    typedef struct packed {
        logic signed [VAL_W-1:0] x_min;
        logic signed [VAL_W-1:0] x_max;
        logic signed [VAL_W-1:0] y_min;
        logic signed [VAL_W-1:0] y_max;
        logic [VAL_W-1:0]        x_scale;
        logic [VAL_W-1:0]        y_scale;
        logic [WIDTH_W-1:0]      x_width;
        logic [WIDTH_W-1:0]      y_width;
    } cfg_t;

endpackage

>>> hw/rtl/hb2d_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hb2d_if: sample and result channels
// Valid/ready channels carrying one sample word and one result word.
// ----------------------------------------------------------------------------
interface hb2d_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic signed [31:0]       sample_x;
    logic signed [31:0]       sample_y;

    modport source (output valid, output mode, output sample_x, output sample_y,
                    input ready);
    modport sink   (input valid, input mode, input sample_x, input sample_y,
                    output ready);
endinterface

interface hb2d_out_if;
    logic                     valid;
    logic                     ready;
    logic                     in_range;
    logic [3:0]               bin_x;
    logic [3:0]               bin_y;
    logic [31:0]              bin_count;
    logic signed [31:0]       center_x;
    logic signed [31:0]       center_y;

    modport source (output valid, output in_range, output bin_x, output bin_y,
                    output bin_count, output center_x, output center_y,
                    input ready);
    modport sink   (input valid, input in_range, input bin_x, input bin_y,
                    input bin_count, input center_x, input center_y,
                    output ready);
endinterface

>>> hw/rtl/hb2d_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hb2d_cfg: APB register file
// Holds the box, scale and bin width registers; pready is tied high.
// ----------------------------------------------------------------------------
module hb2d_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hb2d_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [hb2d_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [hb2d_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output hb2d_pkg::cfg_t                      cfg
);

    hb2d_pkg::cfg_t                        cfg_reg;
    hb2d_pkg::cfg_t                        cfg_next;
    logic [hb2d_pkg::REG_IDX_W-1:0]        reg_idx;
    logic                                  wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[hb2d_pkg::CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                hb2d_pkg::REG_X_MIN:   cfg_next.x_min   = pwdata;
                hb2d_pkg::REG_X_MAX:   cfg_next.x_max   = pwdata;
                hb2d_pkg::REG_Y_MIN:   cfg_next.y_min   = pwdata;
                hb2d_pkg::REG_Y_MAX:   cfg_next.y_max   = pwdata;
                hb2d_pkg::REG_X_SCALE: cfg_next.x_scale = pwdata;
                hb2d_pkg::REG_Y_SCALE: cfg_next.y_scale = pwdata;
                hb2d_pkg::REG_X_WIDTH: cfg_next.x_width = pwdata[hb2d_pkg::WIDTH_W-1:0];
                hb2d_pkg::REG_Y_WIDTH: cfg_next.y_width = pwdata[hb2d_pkg::WIDTH_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_min   <= hb2d_pkg::X_MIN_RST;
            cfg_reg.x_max   <= hb2d_pkg::X_MAX_RST;
            cfg_reg.y_min   <= hb2d_pkg::Y_MIN_RST;
            cfg_reg.y_max   <= hb2d_pkg::Y_MAX_RST;
            cfg_reg.x_scale <= hb2d_pkg::SCALE_RST;
            cfg_reg.y_scale <= hb2d_pkg::SCALE_RST;
            cfg_reg.x_width <= hb2d_pkg::WIDTH_RST;
            cfg_reg.y_width <= hb2d_pkg::WIDTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            hb2d_pkg::REG_X_MIN:   prdata = cfg_reg.x_min;
            hb2d_pkg::REG_X_MAX:   prdata = cfg_reg.x_max;
            hb2d_pkg::REG_Y_MIN:   prdata = cfg_reg.y_min;
            hb2d_pkg::REG_Y_MAX:   prdata = cfg_reg.y_max;
            hb2d_pkg::REG_X_SCALE: prdata = cfg_reg.x_scale;
            hb2d_pkg::REG_Y_SCALE: prdata = cfg_reg.y_scale;
            hb2d_pkg::REG_X_WIDTH: prdata = {1'b0, cfg_reg.x_width};
            hb2d_pkg::REG_Y_WIDTH: prdata = {1'b0, cfg_reg.y_width};
            default:               prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/hb2d_bin.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hb2d_bin: sample to bin index
// Three stages: box test and offset, scale multiply, clamp to the last bin.
// ----------------------------------------------------------------------------
module hb2d_bin
#(
    parameter int BINS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [hb2d_pkg::VAL_W-1:0]   sample_x,
    input  logic signed [hb2d_pkg::VAL_W-1:0]   sample_y,
    input  hb2d_pkg::cfg_t                      cfg,
    output logic                                done,
    output logic                                in_range,
    output logic [$clog2(BINS)-1:0]             idx_x,
    output logic [$clog2(BINS)-1:0]             idx_y
);

    localparam int IDX_W = $clog2(BINS);
    localparam int VW    = hb2d_pkg::VAL_W;

    logic                  s1_vld_reg;
    logic                  s2_vld_reg;
    logic                  done_reg;
    logic                  s1_inr_reg;
    logic                  s2_inr_reg;
    logic                  inr_reg;
    logic [VW-1:0]         dx_reg;
    logic [VW-1:0]         dy_reg;
    logic [VW-1:0]         hx_reg;
    logic [VW-1:0]         hy_reg;
    logic [IDX_W-1:0]      idx_x_reg;
    logic [IDX_W-1:0]      idx_y_reg;
    logic                  inr_next;
    logic [2*VW-1:0]       px;
    logic [2*VW-1:0]       py;

    // Box test, inclusive at both ends
    assign inr_next = (sample_x >= cfg.x_min) && (sample_x <= cfg.x_max) &&
                      (sample_y >= cfg.y_min) && (sample_y <= cfg.y_max);

    // Offset fits 32 bits unsigned whenever the sample is inside the box
    assign px = {{VW{1'b0}}, dx_reg} * {{VW{1'b0}}, cfg.x_scale};
    assign py = {{VW{1'b0}}, dy_reg} * {{VW{1'b0}}, cfg.y_scale};

    // Advance the stage flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start;
            s2_vld_reg <= s1_vld_reg;
            done_reg   <= s2_vld_reg;
        end
    end

    // Stage datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dx_reg     <= VW'(sample_x - cfg.x_min);
            dy_reg     <= VW'(sample_y - cfg.y_min);
            s1_inr_reg <= inr_next;
        end
        if (s1_vld_reg)
        begin
            hx_reg     <= px[2*VW-1:VW];
            hy_reg     <= py[2*VW-1:VW];
            s2_inr_reg <= s1_inr_reg;
        end
        if (s2_vld_reg)
        begin
            idx_x_reg <= (hx_reg > VW'(BINS - 1)) ? IDX_W'(BINS - 1) : hx_reg[IDX_W-1:0];
            idx_y_reg <= (hy_reg > VW'(BINS - 1)) ? IDX_W'(BINS - 1) : hy_reg[IDX_W-1:0];
            inr_reg   <= s2_inr_reg;
        end
    end

    assign done     = done_reg;
    assign in_range = inr_reg;
    assign idx_x    = idx_x_reg;
    assign idx_y    = idx_y_reg;

endmodule

>>> hw/rtl/hb2d_centre.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hb2d_centre: peak bin centre
// centre = min + width/2 + width*index, saturated to signed 32 bits.
// ----------------------------------------------------------------------------
module hb2d_centre
#(
    parameter int BINS = 16
)
(
    input  logic                                clk,
    input  logic                                start,
    input  hb2d_pkg::cfg_t                      cfg,
    input  logic [$clog2(BINS)-1:0]             idx_x,
    input  logic [$clog2(BINS)-1:0]             idx_y,
    output logic signed [hb2d_pkg::VAL_W-1:0]   center_x,
    output logic signed [hb2d_pkg::VAL_W-1:0]   center_y
);

    localparam int IDX_W = $clog2(BINS);
    localparam int WW    = hb2d_pkg::WIDTH_W;
    localparam int VW    = hb2d_pkg::VAL_W;
    localparam int CW    = WW + IDX_W + 3;

    logic signed [CW-1:0]  sum_x;
    logic signed [CW-1:0]  sum_y;
    logic signed [VW-1:0]  cx_reg;
    logic signed [VW-1:0]  cy_reg;

    // Exact sum: all terms fit CW bits
    assign sum_x = CW'(cfg.x_min)
                 + $signed(CW'({1'b0, cfg.x_width[WW-1:1]}))
                 + $signed(CW'(cfg.x_width) * CW'(idx_x));
    assign sum_y = CW'(cfg.y_min)
                 + $signed(CW'({1'b0, cfg.y_width[WW-1:1]}))
                 + $signed(CW'(cfg.y_width) * CW'(idx_y));

    function automatic logic signed [VW-1:0] clip(input logic signed [CW-1:0] v);
        logic signed [VW-1:0] r;
        if (!v[CW-1] && (|v[CW-2:VW-1]))
            r = {1'b0, {(VW-1){1'b1}}};
        else if (v[CW-1] && !(&v[CW-2:VW-1]))
            r = {1'b1, {(VW-1){1'b0}}};
        else
            r = v[VW-1:0];
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cx_reg <= clip(sum_x);
            cy_reg <= clip(sum_y);
        end
    end

    assign center_x = cx_reg;
    assign center_y = cy_reg;

endmodule

>>> hw/rtl/histogram_2d_bin_peak.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_2d_bin_peak: two-dimensional histogram with peak search
// BINS x BINS saturating counts in one synchronous RAM, updated by
// read-modify-write; a peak word sweeps the RAM and reports the first maximum.
// ----------------------------------------------------------------------------
//  channel     dir  handshake        word
//  sample_in   in   valid/ready      mode, sample_x, sample_y
//  result_out  out  valid/ready      in_range, bin_x, bin_y, bin_count,
//                                    center_x, center_y
//  APB         in   psel/penable     8 registers at byte address 4*i
//
//  Steps per word, from accept: add/remove in the box runs the 3-stage
//  bin unit, a RAM read, the write-back and the output load; out of the
//  box skips the RAM read and write-back; mode 3 only loads the output; peak
//  sweeps all entries, one RAM read a cycle. One word is worked at a time.
//  After reset a clearing pass writes zero to all BINS*BINS entries, one per
//  cycle; sample_in.ready stays low meanwhile, APB writes are taken.
//  A waiting result does not block the next accept; it blocks only the next
//  result load.
// ----------------------------------------------------------------------------
module histogram_2d_bin_peak
#(
    parameter int BINS       = 16,
    parameter int COUNT_BITS = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hb2d_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [hb2d_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [hb2d_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    hb2d_in_if.sink                             sample_in,
    hb2d_out_if.source                          result_out
);

    localparam int IDX_W  = $clog2(BINS);
    localparam int DEPTH  = BINS * BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BW     = hb2d_pkg::BIN_W;
    localparam int NW     = hb2d_pkg::CNT_W;
    localparam int VW     = hb2d_pkg::VAL_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_BIN   = 4'd2;
    localparam logic [3:0] S_UPD   = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_SCANW = 4'd5;
    localparam logic [3:0] S_CENT  = 4'd6;
    localparam logic [3:0] S_CWAIT = 4'd7;
    localparam logic [3:0] S_RES   = 4'd8;

    hb2d_pkg::cfg_t            cfg;

    logic [3:0]                state_reg;
    logic [3:0]                state_next;
    logic [1:0]                mode_reg;
    logic [ADDR_W-1:0]         clr_addr_reg;
    logic [IDX_W-1:0]          scan_x_reg;
    logic [IDX_W-1:0]          scan_y_reg;
    logic                      cmp_vld_reg;
    logic [IDX_W-1:0]          cmp_x_reg;
    logic [IDX_W-1:0]          cmp_y_reg;
    logic [COUNT_BITS-1:0]     best_reg;
    logic [IDX_W-1:0]          best_x_reg;
    logic [IDX_W-1:0]          best_y_reg;

    logic                      res_inr_reg;
    logic [BW-1:0]             res_bx_reg;
    logic [BW-1:0]             res_by_reg;
    logic [NW-1:0]             res_cnt_reg;
    logic signed [VW-1:0]      res_cx_reg;
    logic signed [VW-1:0]      res_cy_reg;

    logic                      out_vld_reg;
    logic                      out_inr_reg;
    logic [BW-1:0]             out_bx_reg;
    logic [BW-1:0]             out_by_reg;
    logic [NW-1:0]             out_cnt_reg;
    logic signed [VW-1:0]      out_cx_reg;
    logic signed [VW-1:0]      out_cy_reg;

    logic [COUNT_BITS-1:0]     mem [DEPTH];
    logic [COUNT_BITS-1:0]     rd_data_reg;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         wr_addr;
    logic [COUNT_BITS-1:0]     wr_data;
    logic                      wr_en;

    logic                      in_acc;
    logic                      bin_start;
    logic                      bin_done;
    logic                      bin_inr;
    logic [IDX_W-1:0]          bin_ix;
    logic [IDX_W-1:0]          bin_iy;
    logic [ADDR_W-1:0]         upd_addr;
    logic [ADDR_W-1:0]         scan_addr;
    logic [COUNT_BITS-1:0]     new_cnt;
    logic                      res_load;
    logic signed [VW-1:0]      cen_x;
    logic signed [VW-1:0]      cen_y;

    // Register file
    hb2d_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sample to bin index
    hb2d_bin #(.BINS(BINS)) u_bin
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (bin_start),
        .sample_x (sample_in.sample_x),
        .sample_y (sample_in.sample_y),
        .cfg      (cfg),
        .done     (bin_done),
        .in_range (bin_inr),
        .idx_x    (bin_ix),
        .idx_y    (bin_iy)
    );

    // Peak centre
    hb2d_centre #(.BINS(BINS)) u_centre
    (
        .clk      (clk),
        .start    (state_reg == S_CENT),
        .cfg      (cfg),
        .idx_x    (best_x_reg),
        .idx_y    (best_y_reg),
        .center_x (cen_x),
        .center_y (cen_y)
    );

    assign sample_in.ready = (state_reg == S_IDLE);
    assign in_acc          = sample_in.valid && (state_reg == S_IDLE);
    assign bin_start       = in_acc && ((sample_in.mode == hb2d_pkg::MODE_ADD) ||
                                        (sample_in.mode == hb2d_pkg::MODE_REMOVE));

    assign upd_addr  = ADDR_W'(bin_ix) + ADDR_W'(BINS) * ADDR_W'(bin_iy);
    assign scan_addr = ADDR_W'(scan_x_reg) + ADDR_W'(BINS) * ADDR_W'(scan_y_reg);

    // Saturating update of the count read back
    always_comb
    begin
        new_cnt = rd_data_reg;
        if (mode_reg == hb2d_pkg::MODE_ADD)
        begin
            if (rd_data_reg != {COUNT_BITS{1'b1}})
                new_cnt = rd_data_reg + COUNT_BITS'(1);
        end
        else
        begin
            if (rd_data_reg != '0)
                new_cnt = rd_data_reg - COUNT_BITS'(1);
        end
    end

    // RAM port selection
    assign rd_addr = (state_reg == S_SCAN) ? scan_addr : upd_addr;
    assign wr_en   = (state_reg == S_CLEAR) || (state_reg == S_UPD);
    assign wr_addr = (state_reg == S_CLEAR) ? clr_addr_reg : upd_addr;
    assign wr_data = (state_reg == S_CLEAR) ? '0 : new_cnt;

    // Count memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (bin_start)
                        state_next = S_BIN;
                    else if (sample_in.mode == hb2d_pkg::MODE_PEAK)
                        state_next = S_SCAN;
                    else
                        state_next = S_RES;
                end
            end
            S_BIN:
            begin
                if (bin_done)
                    state_next = bin_inr ? S_UPD : S_RES;
            end
            S_UPD:   state_next = S_RES;
            S_SCAN:
            begin
                if ((scan_x_reg == IDX_W'(BINS - 1)) && (scan_y_reg == IDX_W'(BINS - 1)))
                    state_next = S_SCANW;
            end
            S_SCANW: state_next = S_CENT;
            S_CENT:  state_next = S_CWAIT;
            S_CWAIT: state_next = S_RES;
            S_RES:
            begin
                if (!out_vld_reg || result_out.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign res_load = (state_reg == S_RES) && (!out_vld_reg || result_out.ready);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= (state_reg == S_SCAN);
            if (state_reg == S_CLEAR)
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (res_load)
                out_vld_reg <= 1'b1;
            else if (result_out.ready)
                out_vld_reg <= 1'b0;
        end
    end

    // Scan, compare and result staging
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mode_reg   <= sample_in.mode;
            scan_x_reg <= '0;
            scan_y_reg <= '0;
            best_reg   <= '0;
            best_x_reg <= '0;
            best_y_reg <= '0;
            res_inr_reg <= 1'b0;
            res_bx_reg  <= '0;
            res_by_reg  <= '0;
            res_cnt_reg <= '0;
            res_cx_reg  <= '0;
            res_cy_reg  <= '0;
        end

        // Walk y inside x
        if (state_reg == S_SCAN)
        begin
            cmp_x_reg <= scan_x_reg;
            cmp_y_reg <= scan_y_reg;
            if (scan_y_reg == IDX_W'(BINS - 1))
            begin
                scan_y_reg <= '0;
                scan_x_reg <= scan_x_reg + IDX_W'(1);
            end
            else
            begin
                scan_y_reg <= scan_y_reg + IDX_W'(1);
            end
        end

        // Keep the first strict maximum
        if (cmp_vld_reg && (rd_data_reg > best_reg))
        begin
            best_reg   <= rd_data_reg;
            best_x_reg <= cmp_x_reg;
            best_y_reg <= cmp_y_reg;
        end

        if (state_reg == S_UPD)
        begin
            res_inr_reg <= 1'b1;
            res_bx_reg  <= BW'(bin_ix);
            res_by_reg  <= BW'(bin_iy);
            res_cnt_reg <= NW'(new_cnt);
        end

        if (state_reg == S_CWAIT)
        begin
            res_inr_reg <= 1'b1;
            res_bx_reg  <= BW'(best_x_reg);
            res_by_reg  <= BW'(best_y_reg);
            res_cnt_reg <= NW'(best_reg);
            res_cx_reg  <= cen_x;
            res_cy_reg  <= cen_y;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_inr_reg <= res_inr_reg;
            out_bx_reg  <= res_bx_reg;
            out_by_reg  <= res_by_reg;
            out_cnt_reg <= res_cnt_reg;
            out_cx_reg  <= res_cx_reg;
            out_cy_reg  <= res_cy_reg;
        end
    end

    assign result_out.valid     = out_vld_reg;
    assign result_out.in_range  = out_inr_reg;
    assign result_out.bin_x     = out_bx_reg;
    assign result_out.bin_y     = out_by_reg;
    assign result_out.bin_count = out_cnt_reg;
    assign result_out.center_x  = out_cx_reg;
    assign result_out.center_y  = out_cy_reg;

endmodule

>>> hw/rtl/hb2d_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hb2d_check: port-level checks of the histogram
// Watches the sample and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module hb2d_check
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                in_range,
    input  logic [3:0]          bin_x,
    input  logic [3:0]          bin_y,
    input  logic [31:0]         bin_count,
    input  logic signed [31:0]  center_x,
    input  logic signed [31:0]  center_y
);

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bin_count) &&
            $stable(bin_x) && $stable(bin_y) && $stable(in_range) &&
            $stable(center_x) && $stable(center_y))
        else $error("result word changed while stalled");

    // Result valid drops only after a take
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result word dropped without a take");

    // One word is worked at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample accepted on two successive cycles");

    // An out of box or empty result carries only zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> (bin_x == 4'd0) && (bin_y == 4'd0) &&
            (bin_count == 32'd0) && (center_x == 32'sd0) && (center_y == 32'sd0))
        else $error("result out of box carries non-zero fields");

endmodule

bind histogram_2d_bin_peak hb2d_check u_hb2d_check
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .in_range  (result_out.in_range),
    .bin_x     (result_out.bin_x),
    .bin_y     (result_out.bin_y),
    .bin_count (result_out.bin_count),
    .center_x  (result_out.center_x),
    .center_y  (result_out.center_y)
);
